[src/residual_norm_assert.svh]
// assertion macros used by the residual norm top level rtl
`ifndef RESIDUAL_NORM_ASSERT_SVH
`define RESIDUAL_NORM_ASSERT_SVH

// same-cycle implication, masked while reset is low
`define RN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition that must hold in the cycle after a reset cycle
`define RN_ASSERT_AFTER_RESET(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

[src/rn_pkg.sv]
package rn_pkg;

    localparam int MAX_SIZE    = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int COL_W       = 6;
    localparam int COL_RANGE   = 2 ** COL_W;
    localparam int VAL_W       = 32;
    localparam int ACC_W       = 64;
    localparam int ROOT_W      = ACC_W / 2;

    // request codes on the input channel; the fourth code is dropped
    typedef enum logic [1:0] {
        REQ_LOAD_X  = 2'd0,
        REQ_ENTRY   = 2'd1,
        REQ_ROW_END = 2'd2
    } t_req;

    // work item handed from the front to the back through the queue
    typedef struct packed {
        logic                    row_end;
        logic                    last;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] x;
    } t_op;

endpackage

[src/rn_ram.sv]
module rn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[src/rn_fifo.sv]
module rn_fifo #(
    parameter int DEPTH = rn_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  rn_pkg::t_op i_data,
    output logic        o_full,
    input  logic        i_pop,
    output rn_pkg::t_op o_data,
    output logic        o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rn_pkg::t_op r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_do_push, w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push & ~o_full;
    assign w_do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_do_push & ~w_do_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_do_pop & ~w_do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[src/rn_front.sv]
module rn_front #(
    parameter int MAX_SIZE = rn_pkg::MAX_SIZE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic [1:0]                      i_req_type,
    input  logic [rn_pkg::COL_W-1:0]        i_col_index,
    input  logic signed [rn_pkg::VAL_W-1:0] i_value,
    input  logic                            i_last_row,
    output logic                            o_full,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output rn_pkg::t_op                     o_q_data
);

    localparam int STORE_DEPTH = (MAX_SIZE < rn_pkg::COL_RANGE) ? MAX_SIZE : rn_pkg::COL_RANGE;
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic                     w_accept;
    logic                     w_in_range;
    logic                     w_is_load, w_is_entry, w_is_end;
    logic [rn_pkg::VAL_W-1:0] w_rdata;

    // one slot waiting for the store read
    logic                            r_s1_valid, n_s1_valid;
    logic                            r_s1_end;
    logic                            r_s1_last;
    logic                            r_s1_in_range;
    logic signed [rn_pkg::VAL_W-1:0] r_s1_value;

    assign w_is_load  = (i_req_type == rn_pkg::REQ_LOAD_X);
    assign w_is_entry = (i_req_type == rn_pkg::REQ_ENTRY);
    assign w_is_end   = (i_req_type == rn_pkg::REQ_ROW_END);
    assign w_in_range = (int'(i_col_index) < MAX_SIZE);

    assign o_full   = r_s1_valid & i_q_full;
    assign w_accept = i_push & ~o_full;
    assign o_q_push = r_s1_valid & ~i_q_full;

    rn_ram #(
        .WIDTH (rn_pkg::VAL_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_accept & w_is_load & w_in_range),
        .i_waddr (i_col_index[AW-1:0]),
        .i_wdata (i_value),
        .i_re    (w_accept & w_is_entry),
        .i_raddr (i_col_index[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        o_q_data.row_end = r_s1_end;
        o_q_data.last    = r_s1_last;
        o_q_data.value   = r_s1_value;
        // columns past the store add nothing
        o_q_data.x       = (r_s1_end | ~r_s1_in_range) ? '0 : signed'(w_rdata);
    end

    always_comb begin
        n_s1_valid = r_s1_valid & ~o_q_push;
        if (w_accept & (w_is_entry | w_is_end)) begin
            n_s1_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept & (w_is_entry | w_is_end)) begin
            r_s1_end      <= w_is_end;
            r_s1_last     <= i_last_row;
            r_s1_in_range <= w_in_range;
            r_s1_value    <= i_value;
        end
    end

endmodule

[src/rn_isqrt.sv]
module rn_isqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rn_pkg::ACC_W-1:0]  i_radicand,
    output logic                      o_busy,
    output logic [rn_pkg::ROOT_W-1:0] o_root
);

    localparam int RW = rn_pkg::ROOT_W + 2;
    localparam int CW = $clog2(rn_pkg::ROOT_W);

    logic                      r_busy;
    logic [CW-1:0]             r_cnt;
    logic [rn_pkg::ACC_W-1:0]  r_rad;
    logic [RW-1:0]             r_rem;
    logic [rn_pkg::ROOT_W-1:0] r_root;
    logic [RW+1:0]             w_shifted;
    logic [RW+1:0]             w_trial;
    logic                      w_take;

    // one result bit per cycle, two radicand bits brought down each step
    assign w_shifted = {r_rem, r_rad[rn_pkg::ACC_W-1 -: 2]};
    assign w_trial   = {2'b00, r_root, 2'b01};
    assign w_take    = (w_shifted >= w_trial);
    assign o_busy    = r_busy;
    assign o_root    = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            if (r_cnt == CW'(rn_pkg::ROOT_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[rn_pkg::ACC_W-3:0], 2'b00};
            if (w_take) begin
                r_rem  <= RW'(w_shifted - w_trial);
                r_root <= {r_root[rn_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_shifted[RW-1:0];
                r_root <= {r_root[rn_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

endmodule

[src/rn_back.sv]
module rn_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_empty,
    input  rn_pkg::t_op               i_q_data,
    output logic                      o_q_pop,
    output logic                      o_root_start,
    output logic [rn_pkg::ACC_W-1:0]  o_root_radicand,
    input  logic                      i_root_busy,
    input  logic [rn_pkg::ROOT_W-1:0] i_root,
    input  logic                      i_pop,
    output logic                      o_empty,
    output logic [rn_pkg::ROOT_W-1:0] o_residual_norm,
    output logic [rn_pkg::ACC_W-1:0]  o_sum_of_squares,
    output logic                      o_overflow
);

    localparam int AW = rn_pkg::ACC_W;
    localparam int VW = rn_pkg::VAL_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ACC  = 7'b0000010,
        S_RND  = 7'b0000100,
        S_SQR  = 7'b0001000,
        S_SUM  = 7'b0010000,
        S_ROOT = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    typedef struct packed {
        logic                 ovf;
        logic signed [AW-1:0] sum;
    } t_sat_sum;

    function automatic t_sat_sum sat_add(input logic signed [AW-1:0] a,
                                         input logic signed [AW-1:0] b);
        t_sat_sum res;
        res.sum = a + b;
        res.ovf = (a[AW-1] == b[AW-1]) && (res.sum[AW-1] != a[AW-1]);
        if (res.ovf) begin
            res.sum = a[AW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end
        return res;
    endfunction

    t_state               r_state, n_state;
    logic signed [AW-1:0] r_acc, n_acc;
    logic signed [AW-1:0] r_prod, n_prod;
    logic signed [AW-1:0] r_res, n_res;
    logic                 r_end, n_end;
    logic                 r_last, n_last;
    logic [VW-1:0]        r_mag, n_mag;
    logic [AW-1:0]        r_sq, n_sq;
    logic [AW-1:0]        r_ssq, n_ssq;
    logic                 r_sat, n_sat;
    logic                 r_out_valid, n_out_valid;
    logic                 w_load_out;

    logic signed [AW-1:0] w_mul;
    logic signed [AW-1:0] w_bneg;
    t_sat_sum             w_acc;
    t_sat_sum             w_rnd;
    logic signed [AW-1:0] w_q;
    logic                 w_q_hi, w_q_lo;
    logic signed [VW-1:0] w_rq;
    logic [AW:0]          w_ssq_sum;
    logic [AW-1:0]        w_ssq_next;

    assign w_mul  = i_q_data.value * i_q_data.x;
    assign w_bneg = -(AW'(i_q_data.value) <<< (VW / 2));
    assign w_acc  = sat_add(r_acc, r_prod);

    // round half up to q16.16, then clamp to 32 bits
    assign w_rnd  = sat_add(r_res, AW'(64'sd32768));
    assign w_q    = w_rnd.sum >>> (VW / 2);
    assign w_q_hi = ~w_q[AW-1] & (|w_q[AW-2:VW-1]);
    assign w_q_lo = w_q[AW-1] & ~(&w_q[AW-2:VW-1]);
    always_comb begin
        if (w_q_hi) begin
            w_rq = {1'b0, {(VW-1){1'b1}}};
        end else if (w_q_lo) begin
            w_rq = {1'b1, {(VW-1){1'b0}}};
        end else begin
            w_rq = w_q[VW-1:0];
        end
    end

    assign w_ssq_sum       = {1'b0, r_ssq} + {1'b0, r_sq};
    assign w_ssq_next      = w_ssq_sum[AW] ? {AW{1'b1}} : w_ssq_sum[AW-1:0];
    assign o_root_radicand = w_ssq_next;
    assign o_empty         = ~r_out_valid;
    assign w_load_out      = (r_state == S_EMIT) & (~r_out_valid | i_pop);

    always_comb begin
        n_state      = r_state;
        n_acc        = r_acc;
        n_prod       = r_prod;
        n_res        = r_res;
        n_end        = r_end;
        n_last       = r_last;
        n_mag        = r_mag;
        n_sq         = r_sq;
        n_ssq        = r_ssq;
        n_sat        = r_sat;
        n_out_valid  = r_out_valid & ~i_pop;
        o_q_pop      = 1'b0;
        o_root_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_prod  = i_q_data.row_end ? w_bneg : w_mul;
                    n_end   = i_q_data.row_end;
                    n_last  = i_q_data.last;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_sat = r_sat | w_acc.ovf;
                if (r_end) begin
                    n_res   = w_acc.sum;
                    n_acc   = '0;
                    n_state = S_RND;
                end else begin
                    n_acc   = w_acc.sum;
                    n_state = S_IDLE;
                end
            end
            S_RND: begin
                n_sat   = r_sat | w_rnd.ovf | w_q_hi | w_q_lo;
                n_mag   = w_rq[VW-1] ? (~w_rq + VW'(1)) : w_rq;
                n_state = S_SQR;
            end
            S_SQR: begin
                n_sq    = AW'(r_mag) * AW'(r_mag);
                n_state = S_SUM;
            end
            S_SUM: begin
                n_ssq = w_ssq_next;
                n_sat = r_sat | w_ssq_sum[AW];
                if (r_last) begin
                    o_root_start = 1'b1;
                    n_state      = S_ROOT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ROOT: begin
                if (!i_root_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_ssq       = '0;
                    n_sat       = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_ssq       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_ssq       <= n_ssq;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_res  <= n_res;
        r_end  <= n_end;
        r_last <= n_last;
        r_mag  <= n_mag;
        r_sq   <= n_sq;
        if (w_load_out) begin
            o_residual_norm  <= i_root;
            o_sum_of_squares <= r_ssq;
            o_overflow       <= r_sat;
        end
    end

endmodule

[src/residual_norm.sv]
// residual_norm: euclidean norm of A*x - b, q16.16 operands
// input queue side: drive the request fields and raise push; a transaction
// completes on a clock edge with push high and full low
// request 0 writes x[col_index] into the solution store, request 1 is one
// matrix entry of the current row, request 2 carries b and closes the row;
// last_row on request 2 closes the system and makes one result
// result queue side: while empty is low the result fields are valid and
// held; pop with empty low takes the transaction
// the front takes one transaction per cycle while the work queue has room
// the back takes each matrix entry through a multiply and a saturating add
// (S_IDLE, S_ACC), each closing b through S_IDLE and S_ACC plus rounding,
// squaring and summing, and the last row through the bit-serial square
// root (one root bit per cycle) plus the output load; it finishes each
// entry before it pops the next, so the multiply/add pair sets the rate
// if the result is not popped, the back waits at the next system end and
// the work queue then fills, raising full
// reset clears accumulators, flags and queues; the x store keeps no reset
// and the user must read it only at columns already written; the block does not enforce this
`include "residual_norm_assert.svh"

module residual_norm #(
    parameter int MAX_SIZE    = rn_pkg::MAX_SIZE,
    parameter int QUEUE_DEPTH = rn_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      i_req_type,
    input  logic [rn_pkg::COL_W-1:0]        i_col_index,
    input  logic signed [rn_pkg::VAL_W-1:0] i_value,
    input  logic                            i_last_row,
    output logic                            empty,
    input  logic                            pop,
    output logic [rn_pkg::ROOT_W-1:0]       o_residual_norm,
    output logic [rn_pkg::ACC_W-1:0]        o_sum_of_squares,
    output logic                            o_overflow
);

    // work queue between front and back
    logic        q_push, q_full, q_pop, q_empty;
    rn_pkg::t_op q_wdata, q_rdata;

    // square root unit
    logic                      root_start, root_busy;
    logic [rn_pkg::ACC_W-1:0]  root_radicand;
    logic [rn_pkg::ROOT_W-1:0] root_value;

    // front: store writes and reads, classifies each transaction
    rn_front #(
        .MAX_SIZE (MAX_SIZE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_req_type  (i_req_type),
        .i_col_index (i_col_index),
        .i_value     (i_value),
        .i_last_row  (i_last_row),
        .o_full      (full),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    rn_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // back: accumulate rows, fold residual squares, emit the result
    rn_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_data         (q_rdata),
        .o_q_pop          (q_pop),
        .o_root_start     (root_start),
        .o_root_radicand  (root_radicand),
        .i_root_busy      (root_busy),
        .i_root           (root_value),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_residual_norm  (o_residual_norm),
        .o_sum_of_squares (o_sum_of_squares),
        .o_overflow       (o_overflow)
    );

    rn_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (root_start),
        .i_radicand (root_radicand),
        .o_busy     (root_busy),
        .o_root     (root_value)
    );

    // front never writes a full queue, back never reads an empty one
    `RN_ASSERT_IMPL(a_queue_no_overrun, i_clk, i_rst_n, q_push, !q_full, "queue write while full")
    `RN_ASSERT_IMPL(a_queue_no_underrun, i_clk, i_rst_n, q_pop, !q_empty, "queue read while empty")
    // no result and no pending root right after reset
    `RN_ASSERT_AFTER_RESET(a_reset_idle, i_clk, i_rst_n, empty && !root_busy, "busy after reset")

endmodule

[dv/tb_residual_norm.sv]
`timescale 1ns / 1ps

module tb_residual_norm;

    // request code that the block drops without effect
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // extra wait after the last norm comes out, as a margin
    localparam int SETTLE_CYCLES = 60;
    // long receiver hold-off, enough to fill the work and result queues
    localparam int HOLD_CYCLES   = 600;
    localparam int ITEM_TARGET   = 1650;

    typedef struct packed {
        logic [1:0]               kind;
        logic [rn_pkg::COL_W-1:0] col;
        logic [rn_pkg::VAL_W-1:0] value;
        logic                     last;
    } t_request;

    typedef struct packed {
        logic [rn_pkg::ROOT_W-1:0] norm;
        logic [rn_pkg::ACC_W-1:0]  sum;
        logic                      ovf;
    } t_norm_result;

    // one directed row: the request and, where typed, its known result
    typedef struct packed {
        t_request     rq;
        logic         typed;
        t_norm_result want;
    } t_stim_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            push;
    logic                            full;
    logic [1:0]                      i_req_type;
    logic [rn_pkg::COL_W-1:0]        i_col_index;
    logic signed [rn_pkg::VAL_W-1:0] i_value;
    logic                            i_last_row;
    logic                            empty;
    logic                            pop;
    logic [rn_pkg::ROOT_W-1:0]       o_residual_norm;
    logic [rn_pkg::ACC_W-1:0]        o_sum_of_squares;
    logic                            o_overflow;

    residual_norm uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_req_type       (i_req_type),
        .i_col_index      (i_col_index),
        .i_value          (i_value),
        .i_last_row       (i_last_row),
        .empty            (empty),
        .pop              (pop),
        .o_residual_norm  (o_residual_norm),
        .o_sum_of_squares (o_sum_of_squares),
        .o_overflow       (o_overflow)
    );

    // norm predictor state: solution store, row and square accumulators, flag
    logic signed [rn_pkg::VAL_W-1:0] x_store [rn_pkg::MAX_SIZE];
    bit                              x_loaded [rn_pkg::MAX_SIZE];
    logic signed [rn_pkg::ACC_W-1:0] row_sum;
    logic [rn_pkg::ACC_W-1:0]        square_sum;
    bit                              saturated;

    // norms still owed by the block, oldest first
    t_norm_result expected_norms [$];

    int errors         = 0;
    int items_sent     = 0;
    int tx_gap_max     = 0;
    int rx_gap_max     = 0;
    int rx_hold_cycles = 0;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // signed 64-bit add, clamps at either end and marks saturation
    function automatic logic signed [rn_pkg::ACC_W-1:0] add_clamped(
            input logic signed [rn_pkg::ACC_W-1:0] a,
            input logic signed [rn_pkg::ACC_W-1:0] b);
        logic [rn_pkg::ACC_W:0] wide;
        wide = {a[rn_pkg::ACC_W-1], a} + {b[rn_pkg::ACC_W-1], b};
        if (wide[rn_pkg::ACC_W] != wide[rn_pkg::ACC_W-1]) begin
            saturated = 1'b1;
            return wide[rn_pkg::ACC_W] ? {1'b1, {(rn_pkg::ACC_W-1){1'b0}}}
                                       : {1'b0, {(rn_pkg::ACC_W-1){1'b1}}};
        end
        return wide[rn_pkg::ACC_W-1:0];
    endfunction

    // floor square root, one trial bit at a time from the top
    function automatic logic [rn_pkg::ROOT_W-1:0] floor_root(input logic [rn_pkg::ACC_W-1:0] n);
        logic [rn_pkg::ROOT_W-1:0] root;
        logic [rn_pkg::ROOT_W-1:0] trial;
        logic [rn_pkg::ACC_W-1:0]  wide_trial;
        root = '0;
        for (int b = rn_pkg::ROOT_W - 1; b >= 0; b--) begin
            trial      = root | (rn_pkg::ROOT_W'(1) << b);
            wide_trial = rn_pkg::ACC_W'(trial);
            if (wide_trial * wide_trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // advance the predictor by one accepted request; returns 1 when a norm is due
    function automatic bit apply_request(input t_request rq, output t_norm_result res);
        logic signed [rn_pkg::ACC_W-1:0] product;
        logic signed [rn_pkg::ACC_W-1:0] scaled;
        logic signed [rn_pkg::ACC_W-1:0] resid;
        logic signed [rn_pkg::ACC_W-1:0] shifted;
        logic signed [rn_pkg::ACC_W-1:0] r64;
        logic [rn_pkg::VAL_W-1:0]        rounded;
        logic [rn_pkg::ACC_W-1:0]        mag;
        logic [rn_pkg::ACC_W:0]          total;
        res = '0;
        case (rq.kind)
            rn_pkg::REQ_LOAD_X: begin
                x_store[rq.col]  = rq.value;
                x_loaded[rq.col] = 1'b1;
            end
            rn_pkg::REQ_ENTRY: begin
                product = '0;
                if (x_loaded[rq.col])
                    product = $signed({{32{rq.value[rn_pkg::VAL_W-1]}}, rq.value})
                            * $signed({{32{x_store[rq.col][rn_pkg::VAL_W-1]}},
                                       x_store[rq.col]});
                row_sum = add_clamped(row_sum, product);
            end
            rn_pkg::REQ_ROW_END: begin
                // b moved to q32.32, then subtracted from the row sum
                scaled = $signed({{16{rq.value[rn_pkg::VAL_W-1]}}, rq.value, 16'h0000});
                resid  = add_clamped(row_sum, -scaled);
                // round half up to q16.16, then clamp to 32 bits
                shifted = add_clamped(resid, 64'sd32768) >>> 16;
                if (shifted[rn_pkg::ACC_W-1:rn_pkg::VAL_W-1]
                        != {(rn_pkg::ACC_W-rn_pkg::VAL_W+1){shifted[rn_pkg::ACC_W-1]}}) begin
                    saturated = 1'b1;
                    rounded   = shifted[rn_pkg::ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
                end else begin
                    rounded = shifted[rn_pkg::VAL_W-1:0];
                end
                r64   = $signed({{32{rounded[rn_pkg::VAL_W-1]}}, rounded});
                mag   = r64[rn_pkg::ACC_W-1] ? -r64 : r64;
                total = {1'b0, square_sum} + {1'b0, mag * mag};
                if (total[rn_pkg::ACC_W]) begin
                    saturated  = 1'b1;
                    square_sum = '1;
                end else begin
                    square_sum = total[rn_pkg::ACC_W-1:0];
                end
                row_sum = '0;
                if (rq.last) begin
                    res.norm   = floor_root(square_sum);
                    res.sum    = square_sum;
                    res.ovf    = saturated;
                    square_sum = '0;
                    saturated  = 1'b0;
                    return 1'b1;
                end
            end
            default: begin
            end
        endcase
        return 1'b0;
    endfunction

    function automatic t_request make_request(input logic [1:0] kind,
                                              input logic [rn_pkg::COL_W-1:0] col,
                                              input logic [rn_pkg::VAL_W-1:0] value,
                                              input logic last);
        t_request rq;
        rq.kind  = kind;
        rq.col   = col;
        rq.value = value;
        rq.last  = last;
        return rq;
    endfunction

    function automatic t_stim_row table_row(input logic [1:0] kind,
                                            input logic [rn_pkg::COL_W-1:0] col,
                                            input logic [rn_pkg::VAL_W-1:0] value,
                                            input logic last,
                                            input logic typed = 1'b0,
                                            input logic [rn_pkg::ROOT_W-1:0] norm = '0,
                                            input logic [rn_pkg::ACC_W-1:0] sum = '0,
                                            input logic ovf = 1'b0);
        t_stim_row row;
        row.rq        = make_request(kind, col, value, last);
        row.typed     = typed;
        row.want.norm = norm;
        row.want.sum  = sum;
        row.want.ovf  = ovf;
        return row;
    endfunction

    // operand mix: extremes, small q16.16 values, rounding edges, wide spread
    function automatic logic [rn_pkg::VAL_W-1:0] pick_operand();
        logic [rn_pkg::VAL_W-1:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return {{10{raw[21]}}, raw[21:0]};
            4: return {{16{raw[16]}}, raw[15:0]};
            5: return raw[0] ? 32'hffff_8000 : 32'h0000_8000;
            6: return $signed(raw) >>> $urandom_range(0, 31);
            default: return raw;
        endcase
    endfunction

    function automatic int pick_gap_limit();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 2;
            default: return 16;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [rn_pkg::ACC_W-1:0] got,
                                   input logic [rn_pkg::ACC_W-1:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    // one transaction on the input side; the predictor runs at the accepting edge
    task automatic send_request(input t_request rq, input logic typed, input t_norm_result want);
        int gap;
        t_norm_result predicted;
        gap = $urandom_range(0, tx_gap_max);
        repeat (gap) begin
            @(negedge i_clk);
            push = 1'b0;
        end
        @(negedge i_clk);
        push        = 1'b1;
        i_req_type  = rq.kind;
        i_col_index = rq.col;
        i_value     = rq.value;
        i_last_row  = rq.last;
        do @(posedge i_clk); while (full);
        if (apply_request(rq, predicted))
            expected_norms.push_back(typed ? want : predicted);
        if (rq.kind != REQ_UNUSED)
            items_sent++;
    endtask

    // now and then slip in a dropped code or a stray x load ahead of the request
    task automatic send_mixed(input t_request rq);
        if ($urandom_range(0, 11) == 0) begin
            if ($urandom_range(0, 1) == 0)
                send_request(make_request(REQ_UNUSED,
                                          rn_pkg::COL_W'($urandom_range(0, rn_pkg::COL_RANGE - 1)),
                                          $urandom(), 1'($urandom_range(0, 1))), 1'b0, '0);
            else
                send_request(make_request(rn_pkg::REQ_LOAD_X,
                                          rn_pkg::COL_W'($urandom_range(0, rn_pkg::COL_RANGE - 1)),
                                          pick_operand(), 1'b0), 1'b0, '0);
        end
        send_request(rq, 1'b0, '0);
    endtask

    task automatic release_push();
        @(negedge i_clk);
        push = 1'b0;
    endtask

    task automatic check_result();
        t_norm_result want;
        if (expected_norms.size() == 0) begin
            report_mismatch("transaction with no norm expected", o_sum_of_squares, '0);
            return;
        end
        want = expected_norms.pop_front();
        if (o_residual_norm !== want.norm)
            report_mismatch("residual_norm", rn_pkg::ACC_W'(o_residual_norm),
                            rn_pkg::ACC_W'(want.norm));
        if (o_sum_of_squares !== want.sum)
            report_mismatch("sum_of_squares", o_sum_of_squares, want.sum);
        if (o_overflow !== want.ovf)
            report_mismatch("overflow", rn_pkg::ACC_W'(o_overflow), rn_pkg::ACC_W'(want.ovf));
    endtask

    // result side: random waits per transaction, plus a long hold when asked
    initial begin
        int rx_wait;
        rx_wait = 0;
        pop     = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                pop = 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                pop = 1'b0;
            end else begin
                pop = 1'b1;
            end
            @(posedge i_clk);
            if (pop && !empty) begin
                check_result();
                rx_wait = $urandom_range(0, rx_gap_max);
            end
        end
    end

    // stimulus: directed table, a drain pause, then random systems
    initial begin
        t_stim_row directed [$];
        int dim;
        int base;
        int rows;
        int entries;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_req_type  = rn_pkg::REQ_LOAD_X;
        i_col_index = '0;
        i_value     = '0;
        i_last_row  = 1'b0;
        row_sum     = '0;
        square_sum  = '0;
        saturated   = 1'b0;
        foreach (x_loaded[k])
            x_loaded[k] = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // x = 1.0, most negative, most positive, one lsb
        directed.push_back(table_row(rn_pkg::REQ_LOAD_X, 0, 32'h0001_0000, 1'b0));
        directed.push_back(table_row(rn_pkg::REQ_LOAD_X, 63, 32'h8000_0000, 1'b0));
        directed.push_back(table_row(rn_pkg::REQ_LOAD_X, 1, 32'h7fff_ffff, 1'b0));
        directed.push_back(table_row(rn_pkg::REQ_LOAD_X, 2, 32'h0000_0001, 1'b0));
        // dropped code, even with last_row set
        directed.push_back(table_row(REQ_UNUSED, 5, 32'hffff_ffff, 1'b1));
        // 2.0 * 1.0 with a stray last_row on the entry; norm is 2.0
        directed.push_back(table_row(rn_pkg::REQ_ENTRY, 0, 32'h0002_0000, 1'b1));
        directed.push_back(table_row(rn_pkg::REQ_ROW_END, 63, 32'h0000_0000, 1'b1,
                                     1'b1, 32'h0002_0000, 64'h0000_0004_0000_0000, 1'b0));
        // system of one empty row
        directed.push_back(table_row(rn_pkg::REQ_ROW_END, 0, 32'h0000_0000, 1'b1,
                                     1'b1, 32'h0000_0000, 64'h0, 1'b0));
        // row sum clamps high, residual clamps to the 32-bit maximum
        directed.push_back(table_row(rn_pkg::REQ_ENTRY, 63, 32'h8000_0000, 1'b0));
        directed.push_back(table_row(rn_pkg::REQ_ENTRY, 63, 32'h8000_0000, 1'b0));
        directed.push_back(table_row(rn_pkg::REQ_ROW_END, 0, 32'h8000_0000, 1'b1,
                                     1'b1, 32'h7fff_ffff, 64'h3fff_ffff_0000_0001, 1'b1));
        // five clamped rows overrun the sum of squares
        repeat (4)
            directed.push_back(table_row(rn_pkg::REQ_ROW_END, 0, 32'h8000_0000, 1'b0));
        directed.push_back(table_row(rn_pkg::REQ_ROW_END, 0, 32'h8000_0000, 1'b1,
                                     1'b1, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1));
        // residual clamps to the 32-bit minimum
        directed.push_back(table_row(rn_pkg::REQ_ENTRY, 63, 32'h7fff_ffff, 1'b0));
        directed.push_back(table_row(rn_pkg::REQ_ROW_END, 9, 32'h7fff_ffff, 1'b0));
        // exactly half an lsb rounds up; a minus-half product then opens the next row
        directed.push_back(table_row(rn_pkg::REQ_ENTRY, 2, 32'h0000_8000, 1'b0));
        directed.push_back(table_row(rn_pkg::REQ_ROW_END, 0, 32'h0000_0000, 1'b0));
        directed.push_back(table_row(rn_pkg::REQ_ENTRY, 2, 32'hffff_8000, 1'b0));
        // row sum clamps low on the fourth product
        repeat (3)
            directed.push_back(table_row(rn_pkg::REQ_ENTRY, 1, 32'h8000_0000, 1'b0));
        directed.push_back(table_row(rn_pkg::REQ_ROW_END, 0, 32'hffff_ffff, 1'b1));

        tx_gap_max = 4;
        rx_gap_max = 4;
        foreach (directed[k])
            send_request(directed[k].rq, directed[k].typed, directed[k].want);

        // sender pauses until the block has handed back every norm
        release_push();
        while (expected_norms.size() != 0)
            @(posedge i_clk);

        for (int sys = 0; items_sent < ITEM_TARGET; sys++) begin
            // systems 5..9 go at full rate while the receiver holds off
            if (sys >= 5 && sys < 10) begin
                tx_gap_max = 0;
                if (sys == 5)
                    rx_hold_cycles = HOLD_CYCLES;
            end else begin
                tx_gap_max = pick_gap_limit();
                rx_gap_max = pick_gap_limit();
            end
            // mostly small systems, a few at full size
            dim  = ($urandom_range(0, 24) == 0) ? rn_pkg::MAX_SIZE : $urandom_range(1, 8);
            base = $urandom_range(0, rn_pkg::MAX_SIZE - dim);
            rows = (dim == rn_pkg::MAX_SIZE) ? $urandom_range(1, 2) : $urandom_range(1, 6);
            // columns in use must hold an x; reload most of them anyway
            for (int c = base; c < base + dim; c++) begin
                if (!x_loaded[c] || $urandom_range(0, 3) != 0)
                    send_mixed(make_request(rn_pkg::REQ_LOAD_X, rn_pkg::COL_W'(c),
                                            pick_operand(), $urandom_range(0, 3) == 0));
            end
            for (int r = 0; r < rows; r++) begin
                entries = (dim == rn_pkg::MAX_SIZE) ? rn_pkg::MAX_SIZE
                                                    : $urandom_range(0, dim + 2);
                for (int e = 0; e < entries; e++)
                    send_mixed(make_request(rn_pkg::REQ_ENTRY,
                                            rn_pkg::COL_W'(base + $urandom_range(0, dim - 1)),
                                            pick_operand(), $urandom_range(0, 3) == 0));
                // now and then the closing b lacks last_row and the system runs on
                send_mixed(make_request(rn_pkg::REQ_ROW_END,
                                        rn_pkg::COL_W'($urandom_range(0, rn_pkg::COL_RANGE - 1)),
                                        pick_operand(),
                                        (r == rows - 1) && ($urandom_range(0, 9) != 0)));
            end
        end
        // close whatever system is still open so its norm comes out
        send_request(make_request(rn_pkg::REQ_ROW_END, '0, pick_operand(), 1'b1), 1'b0, '0);

        release_push();
        while (expected_norms.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // hard stop, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/rn_pkg.sv
src/rn_ram.sv
src/rn_fifo.sv
src/rn_front.sv
src/rn_isqrt.sv
src/rn_back.sv
src/residual_norm.sv
dv/tb_residual_norm.sv
